// ----- rtl/prac_pkg.sv -----
package prac_pkg;

  // CORDIC datapath widths: cos/sin in Q1.30, angle in 2^-32-turn units
  localparam int CVW = 32;
  localparam int CZW = 33;

  // gain constant K in Q1.30
  localparam logic signed [CVW-1:0] GAIN_Q30 = 32'sd652032874;

  // atan(2^-i) in 2^-32-turn units
  localparam int ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // vector state carried from cell to cell
  typedef struct packed {
    logic [CVW-1:0] x;
    logic [CVW-1:0] y;
    logic [CZW-1:0] z;
  } cvec_t;

endpackage

// ----- rtl/prac_if.sv -----
interface prac_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] in_x;
  logic [W-1:0] in_y;
  logic [W-1:0] center_x;
  logic [W-1:0] center_y;
  logic [15:0]  angle;

  modport source (output valid, in_x, in_y, center_x, center_y, angle, input ready);
  modport sink   (input valid, in_x, in_y, center_x, center_y, angle, output ready);
endinterface

interface prac_out_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_x;
  logic [W-1:0] out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

// ----- rtl/prac_cell.sv -----
module prac_cell
  import prac_pkg::*;
#(
  parameter int W     = 32,
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  cvec_t        up_vec,
  input  logic [W:0]   up_dx,
  input  logic [W:0]   up_dy,
  input  logic [W-1:0] up_cx,
  input  logic [W-1:0] up_cy,
  input  logic         up_flip,
  output logic         dn_valid,
  input  logic         dn_ready,
  output cvec_t        dn_vec,
  output logic [W:0]   dn_dx,
  output logic [W:0]   dn_dy,
  output logic [W-1:0] dn_cx,
  output logic [W-1:0] dn_cy,
  output logic         dn_flip
);

  logic           valid_r;
  cvec_t          vec_r, vec_nxt;
  logic [W:0]     dx_r, dy_r;
  logic [W-1:0]   cx_r, cy_r;
  logic           flip_r;
  logic           en;
  logic [CVW-1:0] xs, ys;
  logic [CZW-1:0] step;

  // advance when empty or when the next cell takes our item
  assign en       = !valid_r || dn_ready;
  assign up_ready = en;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    xs   = CVW'($signed(up_vec.x) >>> STAGE);
    ys   = CVW'($signed(up_vec.y) >>> STAGE);
    step = {1'b0, ATAN_TURNS[STAGE]};
    if (!up_vec.z[CZW-1]) begin
      vec_nxt.x = up_vec.x - ys;
      vec_nxt.y = up_vec.y + xs;
      vec_nxt.z = up_vec.z - step;
    end else begin
      vec_nxt.x = up_vec.x + ys;
      vec_nxt.y = up_vec.y - xs;
      vec_nxt.z = up_vec.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= vec_nxt;
      dx_r   <= up_dx;
      dy_r   <= up_dy;
      cx_r   <= up_cx;
      cy_r   <= up_cy;
      flip_r <= up_flip;
    end
  end

  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;
  assign dn_dx    = dx_r;
  assign dn_dy    = dy_r;
  assign dn_cx    = cx_r;
  assign dn_cy    = cy_r;
  assign dn_flip  = flip_r;

endmodule

// ----- rtl/prac_post.sv -----
module prac_post
  import prac_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  cvec_t        up_vec,
  input  logic [W:0]   up_dx,
  input  logic [W:0]   up_dy,
  input  logic [W-1:0] up_cx,
  input  logic [W-1:0] up_cy,
  input  logic         up_flip,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_x,
  output logic [W-1:0] dn_y
);

  localparam logic [W+32:0] RND_POS = (W+33)'(1) << 29;
  localparam logic [W+32:0] RND_NEG = RND_POS - (W+33)'(1);

  // ---------------- stage A: split products ----------------
  logic                  va_r, ena;
  logic signed [W+17:0]  xc_lo_r, ys_lo_r, xs_lo_r, yc_lo_r;
  logic signed [W+16:0]  xc_hi_r, ys_hi_r, xs_hi_r, yc_hi_r;
  logic [W-1:0]          cxa_r, cya_r;
  logic [CVW-1:0]        cs, sn;
  logic signed [W:0]     dx, dy;

  // ---------------- stage B: rounded products ----------------
  logic                  vb_r, enb;
  logic [W+1:0]          pxc_r, pys_r, pxs_r, pyc_r;
  logic [W-1:0]          cxb_r, cyb_r;

  // ---------------- stage C: output register ----------------
  logic                  vc_r, enc;
  logic [W-1:0]          ox_r, oy_r, ox_nxt, oy_nxt;
  logic [W+2:0]          sx, sy;

  function automatic logic [W+1:0] round_q30(input logic [W+16:0] hi,
                                             input logic [W+17:0] lo);
    logic [W+32:0] p;
    logic [W+32:0] q;
    p = {hi, 16'b0} + {{15{lo[W+17]}}, lo};
    q = p + (p[W+32] ? RND_NEG : RND_POS);
    return q[W+31:30];
  endfunction

  function automatic logic [W-1:0] sat(input logic [W+2:0] v);
    logic [W-1:0] r;
    if (v[W+2:W-1] == '0 || v[W+2:W-1] == '1) begin
      r = v[W-1:0];
    end else if (v[W+2]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  assign enc      = !vc_r || dn_ready;
  assign enb      = !vb_r || enc;
  assign ena      = !va_r || enb;
  assign up_ready = ena;

  // apply the half-turn fold to cos and sin
  always_comb begin
    cs = up_flip ? CVW'(-up_vec.x) : up_vec.x;
    sn = up_flip ? CVW'(-up_vec.y) : up_vec.y;
    dx = $signed(up_dx);
    dy = $signed(up_dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ena) va_r <= up_valid;
      if (enb) vb_r <= va_r;
      if (enc) vc_r <= vb_r;
    end
  end

  // multiply by the low and high halves of cos and sin
  always_ff @(posedge clk) begin
    if (ena) begin
      xc_lo_r <= dx * $signed({1'b0, cs[15:0]});
      xc_hi_r <= dx * $signed(cs[31:16]);
      ys_lo_r <= dy * $signed({1'b0, sn[15:0]});
      ys_hi_r <= dy * $signed(sn[31:16]);
      xs_lo_r <= dx * $signed({1'b0, sn[15:0]});
      xs_hi_r <= dx * $signed(sn[31:16]);
      yc_lo_r <= dy * $signed({1'b0, cs[15:0]});
      yc_hi_r <= dy * $signed(cs[31:16]);
      cxa_r   <= up_cx;
      cya_r   <= up_cy;
    end
  end

  // join halves and round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (enb) begin
      pxc_r <= round_q30(xc_hi_r, xc_lo_r);
      pys_r <= round_q30(ys_hi_r, ys_lo_r);
      pxs_r <= round_q30(xs_hi_r, xs_lo_r);
      pyc_r <= round_q30(yc_hi_r, yc_lo_r);
      cxb_r <= cxa_r;
      cyb_r <= cya_r;
    end
  end

  // add the center back and saturate
  always_comb begin
    sx = {pxc_r[W+1], pxc_r} - {pys_r[W+1], pys_r} + {{3{cxb_r[W-1]}}, cxb_r};
    sy = {pxs_r[W+1], pxs_r} + {pyc_r[W+1], pyc_r} + {{3{cyb_r[W-1]}}, cyb_r};
    ox_nxt = sat(sx);
    oy_nxt = sat(sy);
  end

  always_ff @(posedge clk) begin
    if (enc) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

  assign dn_valid = vc_r;
  assign dn_x     = ox_r;
  assign dn_y     = oy_r;

endmodule

// ----- rtl/point_rotate_about_center.sv -----
// Channel  Dir  Transfer          Payload
// in_ch    in   valid & ready     in_x, in_y, center_x, center_y, angle
// out_ch   out  valid & ready     out_x, out_y
//
// One point per cycle while out_ch is ready; a point passes the front stage,
// one cell per CORDIC stage up to ATAN_LEN, two product stages, output register.
// Synchronous active-low reset clears only the stage valid bits.
// A stall on out_ch holds each stage only while the stage after it is full,
// so bubbles close up and the input keeps taking points behind a waiting result.
module point_rotate_about_center
  import prac_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  prac_in_if.sink     in_ch,
  prac_out_if.source  out_ch
);

  localparam int W     = COORD_WIDTH;
  localparam int NCELL = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  logic         vld   [NCELL+1];
  logic         rdy   [NCELL+1];
  cvec_t        vec   [NCELL+1];
  logic [W:0]   dxs   [NCELL+1];
  logic [W:0]   dys   [NCELL+1];
  logic [W-1:0] cxs   [NCELL+1];
  logic [W-1:0] cys   [NCELL+1];
  logic         flips [NCELL+1];

  logic         v0_r, en0;
  cvec_t        vec0_r, vec0_nxt;
  logic [W:0]   dx0_r, dy0_r;
  logic [W-1:0] cx0_r, cy0_r;
  logic         flip0_r, flip0_nxt;
  logic [15:0]  ang_red;

  assign en0         = !v0_r || rdy[0];
  assign in_ch.ready = en0;

  // fold angles beyond a quarter turn by a half turn, scale to turn units
  always_comb begin
    flip0_nxt  = in_ch.angle[15] ^ in_ch.angle[14];
    ang_red    = {in_ch.angle[15] ^ flip0_nxt, in_ch.angle[14:0]};
    vec0_nxt.x = GAIN_Q30;
    vec0_nxt.y = '0;
    vec0_nxt.z = {ang_red[15], ang_red, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_ch.valid;
    end
  end

  // subtract the center, exact at one extra bit
  always_ff @(posedge clk) begin
    if (en0) begin
      vec0_r  <= vec0_nxt;
      flip0_r <= flip0_nxt;
      dx0_r   <= {in_ch.in_x[W-1], in_ch.in_x} - {in_ch.center_x[W-1], in_ch.center_x};
      dy0_r   <= {in_ch.in_y[W-1], in_ch.in_y} - {in_ch.center_y[W-1], in_ch.center_y};
      cx0_r   <= in_ch.center_x;
      cy0_r   <= in_ch.center_y;
    end
  end

  assign vld[0]   = v0_r;
  assign vec[0]   = vec0_r;
  assign dxs[0]   = dx0_r;
  assign dys[0]   = dy0_r;
  assign cxs[0]   = cx0_r;
  assign cys[0]   = cy0_r;
  assign flips[0] = flip0_r;

  // CORDIC cell chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    prac_cell #(.W(W), .STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_vec   (vec[i]),
      .up_dx    (dxs[i]),
      .up_dy    (dys[i]),
      .up_cx    (cxs[i]),
      .up_cy    (cys[i]),
      .up_flip  (flips[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_vec   (vec[i+1]),
      .dn_dx    (dxs[i+1]),
      .dn_dy    (dys[i+1]),
      .dn_cx    (cxs[i+1]),
      .dn_cy    (cys[i+1]),
      .dn_flip  (flips[i+1])
    );
  end

  prac_post #(.W(W)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[NCELL]),
    .up_ready (rdy[NCELL]),
    .up_vec   (vec[NCELL]),
    .up_dx    (dxs[NCELL]),
    .up_dy    (dys[NCELL]),
    .up_cx    (cxs[NCELL]),
    .up_cy    (cys[NCELL]),
    .up_flip  (flips[NCELL]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_x     (out_ch.out_x),
    .dn_y     (out_ch.out_y)
  );

endmodule

// ----- rtl/prac_chk.sv -----
module prac_chk #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_x,
  input logic [W-1:0] out_y
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
    else $error("result payload changed while stalled");

  // with the output free, every stage can move, so input is taken
  a_in_ready: assert property (@(posedge clk)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // while a point is offered, the handshake outputs are known
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown({in_ready, out_valid}))
    else $error("handshake output unknown");

endmodule

bind point_rotate_about_center prac_chk #(.W(COORD_WIDTH)) u_prac_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y)
);

// ----- verif/point_rotate_about_center_check.sv -----
module point_rotate_about_center_check #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  prac_in_if   in_mon,
  prac_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_count,
  output int   checked_count
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } rotated_pt_t;

  // CORDIC start vector length (1/gain) in Q1.30
  localparam longint GAIN_K     = 652032874;
  localparam longint COORD_MAX  = 2147483647;
  localparam longint COORD_MIN  = -COORD_MAX - 1;
  localparam int     ATAN_STEPS = 24;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_STEP [ATAN_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838,  5340245,   2670163,   1335087,  667544,   333772,
    166886,    83443,     41722,     20861,    10430,    5215,
    2608,      1304,      652,       326,      163,      81
  };

  rotated_pt_t rotated_q[$];
  int mismatches = 0;
  int checked    = 0;
  int pending    = 0;

  assign mismatch_count = mismatches;
  assign pending_count  = pending;
  assign checked_count  = checked;

  // cos and sin of a binary angle, both in Q1.30
  function automatic void unit_vector(input bit [15:0] ang, output longint c,
                                      output longint s);
    bit [15:0] a;
    bit [15:0] turned;
    bit        flip;
    shortint   sa;
    longint    vx, vy, vz, xs, ys;
    int        i;
    a = ang;
    // fold the left half plane onto the right one, negate at the end
    turned = a + 16'h4000;
    flip   = turned[15];
    if (flip) a = a + 16'h8000;
    sa = shortint'(a);
    vz = sa;
    vz = vz * 65536;
    vx = GAIN_K;
    vy = 0;
    for (i = 0; i < CORDIC_STAGES && i < ATAN_STEPS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vz >= 0) begin
        vx = vx - ys;
        vy = vy + xs;
        vz = vz - ATAN_STEP[i];
      end else begin
        vx = vx + ys;
        vy = vy - xs;
        vz = vz + ATAN_STEP[i];
      end
    end
    c = flip ? -vx : vx;
    s = flip ? -vy : vy;
  endfunction

  // round(a * c / 2^30), ties away from zero
  function automatic longint q30_product(input longint a, input longint c);
    bit [63:0]  ma, mc;
    bit [127:0] prod;
    longint     r;
    ma   = (a < 0) ? -a : a;
    mc   = (c < 0) ? -c : c;
    prod = 128'(ma) * 128'(mc) + (128'd1 << 29);
    prod = prod >> 30;
    r    = prod[63:0];
    return ((a < 0) != (c < 0)) ? -r : r;
  endfunction

  function automatic logic [31:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return 32'h7FFF_FFFF;
    if (v < COORD_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic rotated_pt_t rotate_about(input int px, input int py, input int cx,
                                               input int cy, input bit [15:0] ang);
    longint      dx, dy, c, s, rx, ry;
    rotated_pt_t r;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    unit_vector(ang, c, s);
    rx = q30_product(dx, c) - q30_product(dy, s) + longint'(cx);
    ry = q30_product(dx, s) + q30_product(dy, c) + longint'(cy);
    r.x = clamp_coord(rx);
    r.y = clamp_coord(ry);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, field, $signed(want), want, $signed(got), got);
    end
  endtask

  // check result transfers against the oldest prediction, then queue new ones
  always @(posedge clk) begin
    rotated_pt_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (rotated_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual x=0x%08h y=0x%08h",
                   $time, out_mon.out_x, out_mon.out_y);
        end else begin
          want = rotated_q.pop_front();
          compare_field("out_x", want.x, out_mon.out_x);
          compare_field("out_y", want.y, out_mon.out_y);
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        rotated_q.push_back(rotate_about(in_mon.in_x, in_mon.in_y, in_mon.center_x,
                                         in_mon.center_y, in_mon.angle));
      pending = rotated_q.size();
    end
  end

endmodule

// ----- verif/point_rotate_about_center_test.sv -----
module point_rotate_about_center_test;

  localparam int STAGES       = 16;
  localparam int LATENCY      = STAGES + 4;
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  prac_in_if  #(.W(32)) in_ch();
  prac_out_if #(.W(32)) out_ch();

  int          fail_count;
  int          pending;
  int          checked;
  int          sent     = 0;
  int unsigned cycles   = 0;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;

  point_rotate_about_center #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH  (32)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  point_rotate_about_center_check #(
    .CORDIC_STAGES(STAGES)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatch_count(fail_count),
    .pending_count (pending),
    .checked_count (checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("point_rotate_about_center_test NOT OK");
      $finish;
    end
  end

  // present one point until it transfers, then maybe go idle for a burst
  task automatic offer_point(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [15:0] ang);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.in_x     <= px;
    in_ch.in_y     <= py;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.angle    <= ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: return r;
      3, 4:    return {{12{r[19]}}, r[19:0]};
      5:       return {{24{r[7]}}, r[7:0]} << 16;
      default: begin
        case (r[2:0])
          3'd0:    return 32'h7FFF_FFFF;
          3'd1:    return 32'h8000_0000;
          3'd2:    return 32'h0000_0000;
          3'd3:    return 32'hFFFF_FFFF;
          3'd4:    return 32'h0001_0000;
          3'd5:    return 32'h7FFF_0000;
          3'd6:    return 32'h8000_0001;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  // mostly uniform, with a share right at the quadrant boundaries
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 3) == 0)
      return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(0, 65535));
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          n;
    logic [31:0] px, py, cx, cy;
    in_ch.valid    <= 1'b0;
    in_ch.in_x     <= '0;
    in_ch.in_y     <= '0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.angle    <= '0;
    rst_n          <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // unit point about the origin at each quadrant boundary and some neighbors
    offer_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h3FFF);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h6000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hA000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hBFFF);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hC000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hE000);
    offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
    // off-origin center
    offer_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000, 16'h2000);
    // point on the center stays put
    offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1234);
    // widest offsets, driving both ends of saturation
    offer_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'h0000);
    offer_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'h8000);
    offer_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'h4000);
    offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h2000);
    offer_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'h4000);
    offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    offer_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000);
    in_ch.valid <= 1'b0;

    // drain before the random part, then ask for a long result stall
    while (pending != 0) @(posedge clk);
    hold_req = 1'b1;

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // no idling on either side for the tail
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      px = pick_coord();
      py = pick_coord();
      if ($urandom_range(0, 7) == 0) begin
        cx = px + {{16{1'b0}}, 16'($urandom)};
        cy = py - {{16{1'b0}}, 16'($urandom)};
      end else begin
        cx = pick_coord();
        cy = pick_coord();
      end
      offer_point(px, py, cx, cy, pick_angle());
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("run covered %0d points: quadrant boundaries, coordinate extremes, saturation,",
             sent);
    $display("a long result stall and random gaps on both sides; %0d results compared",
             checked);
    if (fail_count == 0)
      $display("point_rotate_about_center_test OK");
    else
      $display("point_rotate_about_center_test NOT OK");
    $finish;
  end

endmodule
